[design/assert_macros.svh]
// Assertion macros shared by the design files.
// No dependencies; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// ante implies cons in the same cycle, checked out of reset
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// cond must never hold out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

[design/cc_pkg.sv]
// Widths, constants and helpers for the circumcircle circumference block.
// No dependencies.
package cc_pkg;

    localparam int COORD_W     = 32;
    localparam int DIFF_W      = COORD_W + 1;        // signed coordinate difference
    localparam int SQ_W        = 2 * DIFF_W;         // product of two magnitudes
    localparam int LEN_W       = SQ_W + 1;           // squared side length
    localparam int CROSS_W     = SQ_W;               // |cross product|
    localparam int N12_W       = 2 * LEN_W;
    localparam int N_W         = N12_W + LEN_W;      // product of three squared lengths
    localparam int SQRT_SHIFT  = 32;
    localparam int ROOT_W      = (N_W + SQRT_SHIFT + 1) / 2;
    localparam int RAD_W       = 2 * ROOT_W;
    localparam int PI_W        = 62;
    localparam int PROD_W      = ROOT_W + PI_W;
    localparam int GUARD_SHIFT = 76;                 // guard bits plus pi scale
    localparam int NUM_W       = PROD_W - GUARD_SHIFT;
    localparam int OUT_W       = 48;
    localparam int MUL_CHUNK   = 34;

    localparam logic [PI_W-1:0]  PI_Q60  = 62'h3243F6A8885A308D;
    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    typedef struct packed {
        logic [LEN_W-1:0]   ld;
        logic [CROSS_W-1:0] xprod;
        logic               deg;
    } cc_side1_t;

    typedef struct packed {
        logic [CROSS_W-1:0] xprod;
        logic               deg;
    } cc_side2_t;

    typedef struct packed {
        logic [OUT_W-1:0] circumference;
        logic             degenerate;
        logic             saturated;
    } cc_result_t;

    function automatic logic signed [DIFF_W-1:0] sdiff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        return DIFF_W'(a) - DIFF_W'(b);
    endfunction

    function automatic logic [DIFF_W-1:0] mag(input logic signed [DIFF_W-1:0] d);
        return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    endfunction

endpackage

[design/cc_if.sv]
// Valid/ready channel interfaces for the point triples and the results.
// Depends on cc_pkg.
interface cc_in_if import cc_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] p1_x;
    logic signed [COORD_W-1:0] p1_y;
    logic signed [COORD_W-1:0] p2_x;
    logic signed [COORD_W-1:0] p2_y;
    logic signed [COORD_W-1:0] p3_x;
    logic signed [COORD_W-1:0] p3_y;

    modport source (output valid, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, input ready);
    modport sink   (input valid, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, output ready);
endinterface

interface cc_out_if import cc_pkg::*;;
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] circumference;
    logic             degenerate;
    logic             saturated;

    modport source (output valid, circumference, degenerate, saturated, input ready);
    modport sink   (input valid, circumference, degenerate, saturated, output ready);
endinterface

[design/circumcircle_circumference_top.sv]
// Top level of the circumcircle circumference block.
// Depends on cc_pkg, cc_if, cc_mul, cc_sqrt, cc_div and assert_macros.svh.
`include "assert_macros.svh"

// Takes three points (signed Q15.16) per beat and returns 2*pi*R of the circle
// through them (unsigned Q32.16, rounded down), computed exactly as
// pi*|B|*|C|*|D| / |B x C| with wide integers. One beat is accepted every
// cycle while the skid register is empty. The stages are registered
// differences, squares and sums, two wide multipliers, a 117-stage square
// root (one root bit per stage), a multiply by pi, a 49-stage divider (an
// overflow check, then one quotient bit per stage) and the output register.
// The whole pipeline advances together; a skid register behind it absorbs
// one beat when the output is stalled, so a stall drops nothing. Collinear
// points give degenerate=1 with zero; a quotient of 2^48 or more saturates, saturated=1.
module circumcircle_circumference_top import cc_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    cc_in_if.sink    points,
    cc_out_if.source result
);

    localparam int SIDE1_W = $bits(cc_side1_t);
    localparam int SIDE2_W = $bits(cc_side2_t);

    logic adv;

    // stage 1: differences
    logic signed [DIFF_W-1:0] d [6];
    logic                     s1_valid_reg;
    logic [DIFF_W-1:0]        s1_mag_reg [6];
    logic                     s1_sp_reg, s1_sq_reg;

    // stage 2: products
    logic                     s2_valid_reg;
    logic [SQ_W-1:0]          s2_sq_reg [6];
    logic [SQ_W-1:0]          s2_p_reg, s2_q_reg;
    logic                     s2_sp_reg, s2_sq_sgn_reg;

    // stage 3: lengths and cross product
    logic                     s3_valid_reg;
    logic [LEN_W-1:0]         s3_lb_reg, s3_lc_reg, s3_ld_reg;
    logic [CROSS_W-1:0]       s3_cross_reg;
    logic [CROSS_W-1:0]       cross_next;

    cc_side1_t                side1_in, side1_out;
    logic                     m1_valid;
    logic [N12_W-1:0]         m1_p;
    cc_side2_t                side2_in, side2_out, side3_out, side4_out;
    logic                     m2_valid;
    logic [N_W-1:0]           m2_p;
    logic                     sq_valid;
    logic [ROOT_W-1:0]        sq_root;
    logic                     m3_valid;
    logic [PROD_W-1:0]        m3_p;
    logic                     dv_valid;
    logic [OUT_W-1:0]         dv_quo;
    logic                     dv_ovf;
    logic                     dv_deg;

    cc_result_t               inc;
    logic                     inc_take;
    logic                     out_valid_reg, skid_valid_reg;
    cc_result_t               out_data_reg, skid_data_reg;

    // pipeline moves whenever the skid register is free
    assign adv          = !skid_valid_reg;
    assign points.ready = adv;

    assign d[0] = sdiff(points.p2_x, points.p1_x);   // B
    assign d[1] = sdiff(points.p2_y, points.p1_y);
    assign d[2] = sdiff(points.p3_x, points.p1_x);   // C
    assign d[3] = sdiff(points.p3_y, points.p1_y);
    assign d[4] = sdiff(points.p3_x, points.p2_x);   // D
    assign d[5] = sdiff(points.p3_y, points.p2_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= points.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // cross = |Bx*Cy - By*Cx| from magnitudes and product signs
    always_comb
    begin
        if (s2_sp_reg == s2_sq_sgn_reg)
            cross_next = (s2_p_reg >= s2_q_reg) ? s2_p_reg - s2_q_reg : s2_q_reg - s2_p_reg;
        else
            cross_next = s2_p_reg + s2_q_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 6; i++)
            begin
                s1_mag_reg[i] <= mag(d[i]);
                s2_sq_reg[i]  <= SQ_W'(s1_mag_reg[i]) * SQ_W'(s1_mag_reg[i]);
            end
            s1_sp_reg     <= d[0][DIFF_W-1] ^ d[3][DIFF_W-1];
            s1_sq_reg     <= d[1][DIFF_W-1] ^ d[2][DIFF_W-1];
            s2_p_reg      <= SQ_W'(s1_mag_reg[0]) * SQ_W'(s1_mag_reg[3]);
            s2_q_reg      <= SQ_W'(s1_mag_reg[1]) * SQ_W'(s1_mag_reg[2]);
            s2_sp_reg     <= s1_sp_reg;
            s2_sq_sgn_reg <= s1_sq_reg;
            s3_lb_reg     <= LEN_W'(s2_sq_reg[0]) + LEN_W'(s2_sq_reg[1]);
            s3_lc_reg     <= LEN_W'(s2_sq_reg[2]) + LEN_W'(s2_sq_reg[3]);
            s3_ld_reg     <= LEN_W'(s2_sq_reg[4]) + LEN_W'(s2_sq_reg[5]);
            s3_cross_reg  <= cross_next;
        end
    end

    assign side1_in.ld    = s3_ld_reg;
    assign side1_in.xprod = s3_cross_reg;
    assign side1_in.deg   = (s3_cross_reg == '0);

    // |B|^2 * |C|^2
    cc_mul #(.A_W(LEN_W), .B_W(LEN_W), .SIDE_W(SIDE1_W)) u_mul_bc (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .in_valid(s3_valid_reg), .a(s3_lb_reg), .b(s3_lc_reg), .side(side1_in),
        .out_valid(m1_valid), .p(m1_p), .side_out(side1_out)
    );

    assign side2_in.xprod = side1_out.xprod;
    assign side2_in.deg   = side1_out.deg;

    // times |D|^2
    cc_mul #(.A_W(N12_W), .B_W(LEN_W), .SIDE_W(SIDE2_W)) u_mul_n (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .in_valid(m1_valid), .a(m1_p), .b(side1_out.ld), .side(side2_in),
        .out_valid(m2_valid), .p(m2_p), .side_out(side2_out)
    );

    // S = floor(sqrt(N * 2^32))
    cc_sqrt #(.ROOT_BITS(ROOT_W), .SIDE_W(SIDE2_W)) u_sqrt (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .in_valid(m2_valid), .rad(RAD_W'({m2_p, {SQRT_SHIFT{1'b0}}})), .side(side2_out),
        .out_valid(sq_valid), .root(sq_root), .side_out(side3_out)
    );

    // pi (Q60) * S
    cc_mul #(.A_W(ROOT_W), .B_W(PI_W), .SIDE_W(SIDE2_W)) u_mul_pi (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .in_valid(sq_valid), .a(sq_root), .b(PI_Q60), .side(side3_out),
        .out_valid(m3_valid), .p(m3_p), .side_out(side4_out)
    );

    // floor(pi*S / (cross * 2^76)) == floor(floor(pi*S / 2^76) / cross)
    cc_div #(.N_BITS(NUM_W), .D_BITS(CROSS_W), .Q_BITS(OUT_W), .SIDE_W(1)) u_div (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .in_valid(m3_valid), .num(m3_p[PROD_W-1:GUARD_SHIFT]), .den(side4_out.xprod),
        .side(side4_out.deg),
        .out_valid(dv_valid), .quo(dv_quo), .ovf(dv_ovf), .side_out(dv_deg)
    );

    // degenerate wins: its zero divisor makes the overflow check meaningless
    always_comb
    begin
        inc.degenerate = dv_deg;
        if (dv_deg)
            inc.circumference = '0;
        else if (dv_ovf)
            inc.circumference = OUT_MAX;
        else
            inc.circumference = dv_quo;
        inc.saturated = dv_ovf && !dv_deg;
    end

    assign inc_take = dv_valid && adv;

    // output register plus one-beat skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || result.ready)
        begin
            out_valid_reg  <= skid_valid_reg || inc_take;
            skid_valid_reg <= 1'b0;
        end
        else if (inc_take)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || result.ready)
            out_data_reg <= skid_valid_reg ? skid_data_reg : inc;
        else if (inc_take)
            skid_data_reg <= inc;
    end

    assign result.valid         = out_valid_reg;
    assign result.circumference = out_data_reg.circumference;
    assign result.degenerate    = out_data_reg.degenerate;
    assign result.saturated     = out_data_reg.saturated;

    `ASSERT_IMPLIES(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg, "skid holds a beat while output register is empty")
    `ASSERT_NEVER(a_flags_exclusive, clk, rst_n, result.valid && result.degenerate && result.saturated, "degenerate and saturated both set")
    `ASSERT_IMPLIES(a_degenerate_zero, clk, rst_n, result.valid && result.degenerate, result.circumference == '0, "degenerate result not zero")
    `ASSERT_IMPLIES(a_saturated_max, clk, rst_n, result.valid && result.saturated, result.circumference == OUT_MAX, "saturated result not at maximum")

endmodule

[design/cc_mul.sv]
// Two-stage wide unsigned multiplier: chunk partial products, then shifted sum.
// Depends on cc_pkg.
module cc_mul import cc_pkg::*; #(
    parameter int A_W    = LEN_W,
    parameter int B_W    = LEN_W,
    parameter int SIDE_W = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [A_W-1:0]       a,
    input  logic [B_W-1:0]       b,
    input  logic [SIDE_W-1:0]    side,
    output logic                 out_valid,
    output logic [A_W+B_W-1:0]   p,
    output logic [SIDE_W-1:0]    side_out
);

    localparam int NA    = (A_W + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int NB    = (B_W + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int AP_W  = NA * MUL_CHUNK;
    localparam int BP_W  = NB * MUL_CHUNK;
    localparam int PP_W  = 2 * MUL_CHUNK;
    localparam int ACC_W = AP_W + BP_W;

    logic [AP_W-1:0]      a_pad;
    logic [BP_W-1:0]      b_pad;
    logic [PP_W-1:0]      pp_reg [NA][NB];
    logic                 v1_reg;
    logic [SIDE_W-1:0]    side1_reg;
    logic [ACC_W-1:0]     acc;
    logic                 v2_reg;
    logic [SIDE_W-1:0]    side2_reg;
    logic [A_W+B_W-1:0]   p_reg;

    assign a_pad = AP_W'(a);
    assign b_pad = BP_W'(b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NA; i++)
            begin
                for (int j = 0; j < NB; j++)
                begin
                    pp_reg[i][j] <= PP_W'(a_pad[i*MUL_CHUNK +: MUL_CHUNK])
                                  * PP_W'(b_pad[j*MUL_CHUNK +: MUL_CHUNK]);
                end
            end
            side1_reg <= side;
            p_reg     <= acc[A_W+B_W-1:0];
            side2_reg <= side1_reg;
        end
    end

    always_comb
    begin
        acc = '0;
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                acc = acc + (ACC_W'(pp_reg[i][j]) << (MUL_CHUNK * (i + j)));
            end
        end
    end

    assign out_valid = v2_reg;
    assign p         = p_reg;
    assign side_out  = side2_reg;

endmodule

[design/cc_sqrt.sv]
// Pipelined integer square root, one result bit per stage (restoring).
// Depends on cc_pkg.
module cc_sqrt import cc_pkg::*; #(
    parameter int ROOT_BITS = ROOT_W,
    parameter int SIDE_W    = 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [2*ROOT_BITS-1:0] rad,
    input  logic [SIDE_W-1:0]      side,
    output logic                   out_valid,
    output logic [ROOT_BITS-1:0]   root,
    output logic [SIDE_W-1:0]      side_out
);

    localparam int R_W   = 2 * ROOT_BITS;
    localparam int REM_W = ROOT_BITS + 2;

    logic                 v_reg    [ROOT_BITS];
    logic [REM_W-1:0]     rem_reg  [ROOT_BITS];
    logic [ROOT_BITS-1:0] root_reg [ROOT_BITS];
    logic [R_W-1:0]       rad_reg  [ROOT_BITS];
    logic [SIDE_W-1:0]    side_reg [ROOT_BITS];

    for (genvar i = 0; i < ROOT_BITS; i++)
    begin : g_stage
        logic                 v_prev;
        logic [REM_W-1:0]     rem_prev;
        logic [ROOT_BITS-1:0] root_prev;
        logic [R_W-1:0]       rad_prev;
        logic [SIDE_W-1:0]    side_prev;
        logic [REM_W-1:0]     rem_sh;
        logic [REM_W-1:0]     trial;
        logic                 fits;

        if (i == 0)
        begin : g_first
            assign v_prev    = in_valid;
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign rad_prev  = rad;
            assign side_prev = side;
        end
        else
        begin : g_next
            assign v_prev    = v_reg[i-1];
            assign rem_prev  = rem_reg[i-1];
            assign root_prev = root_reg[i-1];
            assign rad_prev  = rad_reg[i-1];
            assign side_prev = side_reg[i-1];
        end

        assign rem_sh = {rem_prev[REM_W-3:0], rad_prev[R_W-1-2*i -: 2]};
        assign trial  = {root_prev, 2'b01};
        assign fits   = rem_sh >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else if (en)
                v_reg[i] <= v_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= fits ? rem_sh - trial : rem_sh;
                root_reg[i] <= {root_prev[ROOT_BITS-2:0], fits};
                rad_reg[i]  <= rad_prev;
                side_reg[i] <= side_prev;
            end
        end
    end

    assign out_valid = v_reg[ROOT_BITS-1];
    assign root      = root_reg[ROOT_BITS-1];
    assign side_out  = side_reg[ROOT_BITS-1];

endmodule

[design/cc_div.sv]
// Pipelined restoring divider: an overflow-check stage, then one quotient bit per stage.
// Depends on cc_pkg.
module cc_div import cc_pkg::*; #(
    parameter int N_BITS = NUM_W,
    parameter int D_BITS = CROSS_W,
    parameter int Q_BITS = OUT_W,
    parameter int SIDE_W = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [N_BITS-1:0]   num,
    input  logic [D_BITS-1:0]   den,
    input  logic [SIDE_W-1:0]   side,
    output logic                out_valid,
    output logic [Q_BITS-1:0]   quo,
    output logic                ovf,
    output logic [SIDE_W-1:0]   side_out
);

    localparam int LIM_W = D_BITS + Q_BITS;

    logic              v_reg    [Q_BITS+1];
    logic [D_BITS-1:0] rem_reg  [Q_BITS+1];
    logic [Q_BITS-1:0] low_reg  [Q_BITS+1];
    logic [Q_BITS-1:0] q_reg    [Q_BITS+1];
    logic [D_BITS-1:0] den_reg  [Q_BITS+1];
    logic              ovf_reg  [Q_BITS+1];
    logic [SIDE_W-1:0] side_reg [Q_BITS+1];

    for (genvar k = 0; k <= Q_BITS; k++)
    begin : g_stage
        logic              v_prev;
        logic [D_BITS-1:0] rem_nx;
        logic [Q_BITS-1:0] low_nx;
        logic [Q_BITS-1:0] q_nx;
        logic [D_BITS-1:0] den_nx;
        logic              ovf_nx;
        logic [SIDE_W-1:0] side_nx;

        if (k == 0)
        begin : g_prep
            // quotient fits only if num < den * 2^Q_BITS
            assign v_prev  = in_valid;
            assign ovf_nx  = LIM_W'(num) >= (LIM_W'(den) << Q_BITS);
            assign rem_nx  = D_BITS'(num[N_BITS-1:Q_BITS]);
            assign low_nx  = num[Q_BITS-1:0];
            assign q_nx    = '0;
            assign den_nx  = den;
            assign side_nx = side;
        end
        else
        begin : g_step
            logic [D_BITS:0] rem_sh;
            logic            fits;

            assign rem_sh  = {rem_reg[k-1], low_reg[k-1][Q_BITS-k]};
            assign fits    = rem_sh >= {1'b0, den_reg[k-1]};
            assign v_prev  = v_reg[k-1];
            assign rem_nx  = fits ? D_BITS'(rem_sh - {1'b0, den_reg[k-1]})
                                  : rem_sh[D_BITS-1:0];
            assign low_nx  = low_reg[k-1];
            assign q_nx    = {q_reg[k-1][Q_BITS-2:0], fits};
            assign den_nx  = den_reg[k-1];
            assign ovf_nx  = ovf_reg[k-1];
            assign side_nx = side_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (en)
                v_reg[k] <= v_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_nx;
                low_reg[k]  <= low_nx;
                q_reg[k]    <= q_nx;
                den_reg[k]  <= den_nx;
                ovf_reg[k]  <= ovf_nx;
                side_reg[k] <= side_nx;
            end
        end
    end

    assign out_valid = v_reg[Q_BITS];
    assign quo       = q_reg[Q_BITS];
    assign ovf       = ovf_reg[Q_BITS];
    assign side_out  = side_reg[Q_BITS];

endmodule

[tb/cc_tb_pkg.sv]
// Shared types for the circumcircle circumference testbench.
// Depends on cc_pkg.
package cc_tb_pkg;
    import cc_pkg::*;

    typedef struct {
        logic signed [COORD_W-1:0] x1, y1, x2, y2, x3, y3;
    } tri_pts_t;

endpackage

[tb/cc_tb_if.sv]
// Testbench-side note: the channel interfaces come from the design (cc_if.sv).
// No dependencies; this file holds a small random burst length helper only.
package cc_tb_util;
    function automatic int burst_len();
        return $urandom_range(15, 1);
    endfunction
endpackage

[tb/tb.sv]
// Self-checking testbench for circumcircle_circumference_top.
// Drives point triples over valid/ready, predicts 2*pi*R exactly with wide
// integers and compares each result beat. Depends on cc_pkg, cc_if, cc_tb_pkg, cc_tb_util.
module tb;
    import cc_pkg::*;
    import cc_tb_pkg::*;
    import cc_tb_util::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    cc_in_if  points();
    cc_out_if result();

    circumcircle_circumference_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .points (points),
        .result (result)
    );

    always #5 clk = ~clk;

    // Expected result beats, oldest first.
    cc_result_t circ_expected[$];
    int errors    = 0;
    int n_sent    = 0;
    int n_checked = 0;
    int n_degen   = 0;
    int n_sat     = 0;
    bit idle_on   = 1'b1;   // random gaps allowed on both sides

    // Exact circumference: floor(PI_Q60 * isqrt(N * 2^32) / (|X| * 2^76)).
    function automatic cc_result_t circ_predict(tri_pts_t t);
        logic signed [63:0] bx, by, cx, cy, dx, dy;
        logic [63:0] abx, aby, acx, acy;
        logic [127:0] p, q, xprod, lb, lc, ld;
        logic [511:0] n, root, trial, num, den;
        cc_result_t r;
        bx = 64'(t.x2) - 64'(t.x1);
        by = 64'(t.y2) - 64'(t.y1);
        cx = 64'(t.x3) - 64'(t.x1);
        cy = 64'(t.y3) - 64'(t.y1);
        dx = 64'(t.x3) - 64'(t.x2);
        dy = 64'(t.y3) - 64'(t.y2);
        abx = bx < 0 ? -bx : bx;
        aby = by < 0 ? -by : by;
        acx = cx < 0 ? -cx : cx;
        acy = cy < 0 ? -cy : cy;
        p = 128'(abx) * 128'(acy);
        q = 128'(aby) * 128'(acx);
        if ((bx < 0) != (cy < 0))
            p = -p;
        if ((by < 0) != (cx < 0))
            q = -q;
        xprod = p - q;
        if (xprod[127])
            xprod = -xprod;
        r = '0;
        if (xprod == 0)
        begin
            r.degenerate = 1'b1;
            return r;
        end
        lb = 128'(abx) * abx + 128'(aby) * aby;
        lc = 128'(acx) * acx + 128'(acy) * acy;
        ld = 128'(dx < 0 ? -dx : dx) ** 2 + 128'(dy < 0 ? -dy : dy) ** 2;
        n = (512'(lb) * 512'(lc) * 512'(ld)) << 32;
        root = '0;
        for (int k = 127; k >= 0; k--)
        begin
            trial = root | (512'(1) << k);
            if (trial * trial <= n)
                root = trial;
        end
        num = 512'(PI_Q60) * root;
        den = 512'(xprod) << 76;
        if (num >= (den << OUT_W))
        begin
            r.circumference = OUT_MAX;
            r.saturated = 1'b1;
        end
        else
            r.circumference = OUT_W'(num / den);
        return r;
    endfunction

    // Send one point triple, with an optional random gap first.
    task automatic send_points(tri_pts_t t);
        if (idle_on && $urandom_range(3, 0) == 0)
        begin
            points.valid <= 1'b0;
            repeat (burst_len()) @(negedge clk);
        end
        points.valid <= 1'b1;
        points.p1_x <= t.x1;
        points.p1_y <= t.y1;
        points.p2_x <= t.x2;
        points.p2_y <= t.y2;
        points.p3_x <= t.x3;
        points.p3_y <= t.y3;
        do @(posedge clk); while (!points.ready);
        circ_expected.push_back(circ_predict(t));
        n_sent++;
        @(negedge clk);
    endtask

    function automatic logic signed [31:0] rnd_coord();
        case ($urandom_range(5, 0))
            0: return $urandom;
            1: return $signed(32'($urandom_range(255, 0))) - 128;
            2: return $urandom_range(1, 0) ? 32'h7FFFFFFF : 32'h80000000;
            default: return $signed($urandom) >>> $urandom_range(28, 0);
        endcase
    endfunction

    task automatic wait_drained();
        int guard;
        guard = 0;
        points.valid <= 1'b0;
        do
        begin
            @(negedge clk);
            guard++;
        end
        while (circ_expected.size() != 0 && guard < 100000);
    endtask

    task automatic test_directed();
        tri_pts_t t;
        // right triangle, unit legs
        t = '{0, 0, 32'sh10000, 0, 0, 32'sh10000};
        send_points(t);
        // coincident points
        t = '{5, 5, 5, 5, 5, 5};
        send_points(t);
        // collinear points
        t = '{0, 0, 1, 1, 2, 2};
        send_points(t);
        // two points equal, third apart
        t = '{0, 0, 0, 0, 7, 3};
        send_points(t);
        // extremes, large triangle
        t = '{32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
              32'sh80000000, 32'sh7FFFFFFF};
        send_points(t);
        t = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
              32'sh7FFFFFFF, 32'sh80000000};
        send_points(t);
        // nearly collinear long triangle: saturates
        t = '{32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFE, 0, 0};
        send_points(t);
        t = '{32'sh80000000, 0, 32'sh7FFFFFFF, 1, 0, 0};
        send_points(t);
        // smallest nonzero triangle
        t = '{0, 0, 1, 0, 0, 1};
        send_points(t);
        t = '{-1, -1, -1, 32'sh7FFFFFFF, 32'sh7FFFFFFF, -1};
        send_points(t);
        t = '{32'shFFFFFFFF, 0, 0, 32'shFFFFFFFF, 32'sh55555555, 32'shAAAAAAAA};
        send_points(t);
    endtask

    task automatic test_random(int count);
        tri_pts_t t;
        for (int i = 0; i < count; i++)
        begin
            t = '{rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                  rnd_coord()};
            // sometimes force collinear or coincident points
            if ($urandom_range(15, 0) == 0)
            begin
                t.x3 = t.x2;
                t.y3 = t.y2;
            end
            send_points(t);
        end
    endtask

    // Result side: random stall bursts on ready.
    initial
    begin
        int stall;
        result.ready = 1'b0;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (idle_on && stall > 0)
            begin
                stall--;
                result.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(7, 0) == 0)
            begin
                stall = burst_len() - 1;
                result.ready <= 1'b0;
            end
            else
                result.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cc_result_t exp_r;
        if (rst_n && result.valid && result.ready)
        begin
            if (circ_expected.size() == 0)
            begin
                $display("%0t: unexpected result beat circ=%h", $time,
                         result.circumference);
                errors++;
            end
            else
            begin
                exp_r = circ_expected.pop_front();
                n_checked++;
                n_degen += exp_r.degenerate;
                n_sat   += exp_r.saturated;
                if (result.circumference !== exp_r.circumference)
                begin
                    $display("%0t: circumference expected %h actual %h", $time,
                             exp_r.circumference, result.circumference);
                    errors++;
                end
                if (result.degenerate !== exp_r.degenerate)
                begin
                    $display("%0t: degenerate expected %b actual %b", $time,
                             exp_r.degenerate, result.degenerate);
                    errors++;
                end
                if (result.saturated !== exp_r.saturated)
                begin
                    $display("%0t: saturated expected %b actual %b", $time,
                             exp_r.saturated, result.saturated);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        points.valid = 1'b0;
        points.p1_x = '0;
        points.p1_y = '0;
        points.p2_x = '0;
        points.p2_y = '0;
        points.p3_x = '0;
        points.p3_y = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random(700);
        // hold off until the pipeline has emptied
        wait_drained();
        test_random(600);
        // no idling on either side from here on: full rate
        idle_on = 1'b0;
        test_random(340);
        wait_drained();
        repeat (200) @(negedge clk);
        if (circ_expected.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time,
                     circ_expected.size());
            errors++;
        end
        $display("Sent %0d point triples, checked %0d results", n_sent, n_checked);
        $display("Collinear cases %0d, saturated cases %0d", n_degen, n_sat);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule

[circumcircle_circumference_top.f]
+incdir+design
design/cc_pkg.sv
design/cc_if.sv
design/cc_mul.sv
design/cc_sqrt.sv
design/cc_div.sv
design/circumcircle_circumference_top.sv
tb/cc_tb_pkg.sv
tb/cc_tb_if.sv
tb/tb.sv
